[src/fbw_pkg.sv]
// ----------------------------------------------------------------------------
// fbw_pkg
// shared types and constants of the four-byte word machine executor
// ----------------------------------------------------------------------------
package fbw_pkg;

   localparam int BLOCK_WORDS = 10;

   typedef enum logic [1:0] {
      FN_CLEAR = 2'd0,
      FN_LOAD  = 2'd1,
      FN_STEP  = 2'd2,
      FN_CARD  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_CARD    = 3'd1,
      ST_PRINT   = 3'd2,
      ST_HALT    = 3'd3,
      ST_BADOP   = 3'd4,
      ST_BADADDR = 3'd5,
      ST_IGNORED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      OP_LR = 3'd0,
      OP_SR = 3'd1,
      OP_CR = 3'd2,
      OP_BT = 3'd3,
      OP_GD = 3'd4,
      OP_PD = 3'd5
   } op_type;

   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_C = 8'h43;
   localparam logic [7:0] CH_B = 8'h42;
   localparam logic [7:0] CH_G = 8'h47;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] CH_H = 8'h48;
   localparam logic [7:0] CH_R = 8'h52;
   localparam logic [7:0] CH_T = 8'h54;
   localparam logic [7:0] CH_D = 8'h44;

endpackage

[src/fbw_req_if.sv]
// ----------------------------------------------------------------------------
// fbw_req_if
// request channel: one word per handshake into the executor
// ----------------------------------------------------------------------------
interface fbw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [6:0]  load_addr;
   logic [31:0] data_word;

   modport source (output valid, output func, output load_addr, output data_word,
                   input ready);
   modport sink   (input valid, input func, input load_addr, input data_word,
                   output ready);
endinterface

[src/fbw_rsp_if.sv]
// ----------------------------------------------------------------------------
// fbw_rsp_if
// response channel: one result word per handshake out of the executor
// ----------------------------------------------------------------------------
interface fbw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] out_word;
   logic        last;
   logic [6:0]  counter_now;
   logic        flag_now;

   modport source (output valid, output status, output out_word, output last,
                   output counter_now, output flag_now, input ready);
   modport sink   (input valid, input status, input out_word, input last,
                   input counter_now, input flag_now, output ready);
endinterface

[src/four_byte_word_machine_executor.sv]
// ----------------------------------------------------------------------------
// four_byte_word_machine_executor
// word machine with MEM_WORDS four-character words stepped one instruction
// at a time, with card input and block print
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken once its last result
// word has been taken. Clear, load and card requests give their result
// straight from idle. A step goes through a fetch read and a decode, and LR
// and CR add an operand read, a second read of the single read port. PD
// takes a fetch, then a read and a data state per printed word for each
// word of the block, and waits when the result side stalls. Memory
// contents are qualified by one valid bit per word, so reset and a new job
// clear empty the memory at once, with no clearing pass.
// ----------------------------------------------------------------------------
module four_byte_word_machine_executor #(
   parameter int MEM_WORDS = 100
) (
   input  logic      clock,
   input  logic      reset,
   fbw_req_if.sink   req_chan,
   fbw_rsp_if.source rsp_chan
);

   localparam int         AW      = $clog2(MEM_WORDS);
   localparam logic [7:0] MW8     = 8'(MEM_WORDS);
   localparam logic [3:0] LAST_K  = 4'(fbw_pkg::BLOCK_WORDS - 1);
   localparam logic [3:0] BLK_CNT = 4'(fbw_pkg::BLOCK_WORDS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FETCH = 5'b00010,
      S_OPER  = 5'b00100,
      S_PREAD = 5'b01000,
      S_PDATA = 5'b10000
   } state_type;

   // memory and its valid bits
   logic [31:0]          mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] valid_ff, valid_in;
   logic [31:0]          mem_rd_ff;
   logic                 mem_rdv_ff;
   logic                 mem_we, mem_re, clr;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [31:0]          mem_wdata;
   logic [31:0]          rword;
   logic [6:0]           paddr;

   state_type           state_ff, state_in;
   logic [6:0]          ic_ff, ic_in;
   logic [31:0]         gr_ff, gr_in;
   logic                flag_ff, flag_in;
   logic                halted_ff, halted_in;
   logic [6:0]          cptr_ff, cptr_in;
   logic [3:0]          cleft_ff, cleft_in;
   fbw_pkg::op_type     op_ff, op_in;
   logic [6:0]          pblk_ff, pblk_in;
   logic [3:0]          k_ff, k_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   fbw_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_word_ff, rsp_word_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [6:0]             rsp_cnt_ff, rsp_cnt_in;
   logic                   rsp_flag_ff, rsp_flag_in;
   logic                   rsp_load, rsp_print;

   // instruction decode
   logic [7:0]      c0, c1, c2, c3;
   logic [6:0]      tens7, tens10, dig_addr;
   logic [7:0]      blk_end;
   logic            op_ok, dig_ok, addr_ok;
   fbw_pkg::op_type dec_op;
   logic            req_acc;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign rword    = mem_rdv_ff ? mem_rd_ff : 32'd0;
   assign paddr    = pblk_ff + {3'd0, k_ff};

   assign c0 = rword[31:24];
   assign c1 = rword[23:16];
   assign c2 = rword[15:8];
   assign c3 = rword[7:0];

   assign tens7    = {3'd0, 4'(c2 - fbw_pkg::CH_0)};
   assign tens10   = (tens7 << 3) + (tens7 << 1);
   assign dig_addr = tens10 + {3'd0, 4'(c3 - fbw_pkg::CH_0)};
   assign blk_end  = {1'b0, tens10} + {4'd0, BLK_CNT};
   assign dig_ok   = (c2 >= fbw_pkg::CH_0) && (c2 <= fbw_pkg::CH_9) &&
                     (c3 >= fbw_pkg::CH_0) && (c3 <= fbw_pkg::CH_9);

   always_comb begin
      op_ok  = 1'b1;
      dec_op = fbw_pkg::OP_LR;
      if (c1 == fbw_pkg::CH_R && c0 == fbw_pkg::CH_L) begin
         dec_op = fbw_pkg::OP_LR;
      end else if (c1 == fbw_pkg::CH_R && c0 == fbw_pkg::CH_S) begin
         dec_op = fbw_pkg::OP_SR;
      end else if (c1 == fbw_pkg::CH_R && c0 == fbw_pkg::CH_C) begin
         dec_op = fbw_pkg::OP_CR;
      end else if (c1 == fbw_pkg::CH_T && c0 == fbw_pkg::CH_B) begin
         dec_op = fbw_pkg::OP_BT;
      end else if (c1 == fbw_pkg::CH_D && c0 == fbw_pkg::CH_G) begin
         dec_op = fbw_pkg::OP_GD;
      end else if (c1 == fbw_pkg::CH_D && c0 == fbw_pkg::CH_P) begin
         dec_op = fbw_pkg::OP_PD;
      end else begin
         op_ok = 1'b0;
      end
   end

   assign addr_ok = dig_ok && ({1'b0, dig_addr} < MW8) &&
                    !((dec_op == fbw_pkg::OP_GD || dec_op == fbw_pkg::OP_PD) &&
                      (blk_end > MW8));

   always_comb begin
      state_in      = state_ff;
      ic_in         = ic_ff;
      gr_in         = gr_ff;
      flag_in       = flag_ff;
      halted_in     = halted_ff;
      cptr_in       = cptr_ff;
      cleft_in      = cleft_ff;
      op_in         = op_ff;
      pblk_in       = pblk_ff;
      k_in          = k_ff;
      clr           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = req_chan.data_word;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      rsp_load      = 1'b0;
      rsp_print     = 1'b0;
      rsp_status_in = fbw_pkg::ST_OK;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               rsp_load = 1'b1;
               case (req_chan.func)
                  fbw_pkg::FN_CLEAR: begin
                     clr       = 1'b1;
                     ic_in     = '0;
                     gr_in     = '0;
                     flag_in   = 1'b0;
                     halted_in = 1'b0;
                     cptr_in   = '0;
                     cleft_in  = '0;
                  end
                  fbw_pkg::FN_LOAD: begin
                     if ({1'b0, req_chan.load_addr} < MW8) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_chan.load_addr[AW-1:0];
                     end else begin
                        rsp_status_in = fbw_pkg::ST_BADADDR;
                     end
                  end
                  fbw_pkg::FN_CARD: begin
                     if (cleft_ff != 4'd0 && {1'b0, cptr_ff} < MW8) begin
                        mem_we        = 1'b1;
                        mem_waddr     = cptr_ff[AW-1:0];
                        cptr_in       = cptr_ff + 7'd1;
                        cleft_in      = cleft_ff - 4'd1;
                        rsp_status_in = (cleft_ff != 4'd1) ? fbw_pkg::ST_CARD
                                                           : fbw_pkg::ST_OK;
                     end else begin
                        rsp_status_in = fbw_pkg::ST_IGNORED;
                     end
                  end
                  default: begin
                     if (halted_ff || cleft_ff != 4'd0) begin
                        rsp_status_in = fbw_pkg::ST_IGNORED;
                     end else if ({1'b0, ic_ff} >= MW8) begin
                        halted_in     = 1'b1;
                        rsp_status_in = fbw_pkg::ST_BADADDR;
                     end else begin
                        rsp_load  = 1'b0;
                        mem_re    = 1'b1;
                        mem_raddr = ic_ff[AW-1:0];
                        ic_in     = ic_ff + 7'd1;
                        state_in  = S_FETCH;
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (c0 == fbw_pkg::CH_H) begin
               halted_in     = 1'b1;
               rsp_status_in = fbw_pkg::ST_HALT;
            end else if (!op_ok) begin
               halted_in     = 1'b1;
               rsp_status_in = fbw_pkg::ST_BADOP;
            end else if (!addr_ok) begin
               halted_in     = 1'b1;
               rsp_status_in = fbw_pkg::ST_BADADDR;
            end else begin
               case (dec_op)
                  fbw_pkg::OP_LR, fbw_pkg::OP_CR: begin
                     rsp_load  = 1'b0;
                     mem_re    = 1'b1;
                     mem_raddr = dig_addr[AW-1:0];
                     op_in     = dec_op;
                     state_in  = S_OPER;
                  end
                  fbw_pkg::OP_SR: begin
                     mem_we    = 1'b1;
                     mem_waddr = dig_addr[AW-1:0];
                     mem_wdata = gr_ff;
                  end
                  fbw_pkg::OP_BT: begin
                     if (flag_ff) begin
                        ic_in = dig_addr;
                     end
                  end
                  fbw_pkg::OP_GD: begin
                     cptr_in       = tens10;
                     cleft_in      = BLK_CNT;
                     rsp_status_in = fbw_pkg::ST_CARD;
                  end
                  default: begin
                     rsp_load = 1'b0;
                     pblk_in  = tens10;
                     k_in     = '0;
                     state_in = S_PREAD;
                  end
               endcase
            end
         end
         S_OPER: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (op_ff == fbw_pkg::OP_LR) begin
               gr_in = rword;
            end else begin
               flag_in = (rword == gr_ff);
            end
         end
         S_PREAD: begin
            mem_re    = 1'b1;
            mem_raddr = paddr[AW-1:0];
            state_in  = S_PDATA;
         end
         S_PDATA: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load      = 1'b1;
               rsp_print     = 1'b1;
               rsp_status_in = fbw_pkg::ST_PRINT;
               rsp_last_in   = (k_ff == LAST_K);
               if (k_ff == LAST_K) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_PREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_word_in  = rsp_print ? rword : gr_in;
      rsp_cnt_in   = ic_in;
      rsp_flag_in  = flag_in;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

      valid_in = valid_ff;
      if (clr) begin
         valid_in = '0;
      end else if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff  <= mem[mem_raddr];
         mem_rdv_ff <= valid_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ic_ff        <= '0;
         gr_ff        <= '0;
         flag_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         cptr_ff      <= '0;
         cleft_ff     <= '0;
         k_ff         <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ic_ff        <= ic_in;
         gr_ff        <= gr_in;
         flag_ff      <= flag_in;
         halted_ff    <= halted_in;
         cptr_ff      <= cptr_in;
         cleft_ff     <= cleft_in;
         k_ff         <= k_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pblk_ff <= pblk_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_flag_ff   <= rsp_flag_in;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_word    = rsp_word_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.counter_now = rsp_cnt_ff;
   assign rsp_chan.flag_now    = rsp_flag_ff;

   // card fill never runs past the end of memory
   a_card_range: assert property (@(posedge clock) disable iff (reset)
      (cleft_ff != 4'd0) |-> (({1'b0, cptr_ff} + {4'd0, cleft_ff}) <= MW8))
      else $error("card fill out of range");

   // print word index stays inside the block
   a_print_idx: assert property (@(posedge clock) disable iff (reset)
      (k_ff <= LAST_K))
      else $error("print index out of block");

   // only printed words can be followed by more words of the same request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != fbw_pkg::ST_PRINT) |-> rsp_chan.last)
      else $error("non-print result without last");

   // a new job clear empties memory at once
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.func == fbw_pkg::FN_CLEAR) |=> (valid_ff == '0))
      else $error("memory not cleared");

   // no request is taken while a print block is in progress
   a_print_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREAD || state_ff == S_PDATA) |=> !$past(req_acc))
      else $error("request taken during print");

endmodule
